// File: rtl/lpr_pkg.sv
`default_nettype none
package lpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  // port widths fixed by the interface
  localparam int PAGE_W      = 16;
  localparam int ALLOT_W     = 5;
  localparam int FRAME_OUT_W = 4;
  localparam int FAULT_W     = 16;

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int RANK_W = IDX_W;

  localparam logic [ALLOT_W-1:0] ALLOT_RESET = ALLOT_W'(4);
  localparam logic [FAULT_W-1:0] FAULT_MAX   = '1;

  // head of the input queue as seen by the back end
  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     limit;
  } lpr_req_t;

  typedef struct packed {
    logic                   hit;
    logic                   filled_free;
    logic                   replaced;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_total;
  } lpr_res_t;

endpackage
`default_nettype wire

// File: rtl/lpr_front.sv
`default_nettype none
module lpr_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [lpr_pkg::PAGE_W-1:0]    in_page_id,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lpr_pkg::ALLOT_W-1:0]   cfg_frames_in_use,
  output lpr_pkg::lpr_req_t                  req,
  input  wire logic                          req_pop
);

  localparam int QD = 2;

  logic [lpr_pkg::PAGE_BITS-1:0] page_q_r [QD];
  logic                          wr_ptr_r;
  logic                          rd_ptr_r;
  logic [1:0]                    cnt_r;
  logic [1:0]                    cnt_nxt;
  logic [lpr_pkg::ALLOT_W-1:0]   allot_r;
  logic [lpr_pkg::CNT_W-1:0]     limit;
  logic                          do_push;
  logic                          do_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = (cnt_r == 2'(QD));
  assign do_push   = in_push && !in_full;
  assign do_pop    = req_pop && (cnt_r != 2'd0);

  // allotment clamped to 1..MAX_FRAMES
  always_comb begin
    if (allot_r == '0) begin
      limit = lpr_pkg::CNT_W'(1);
    end else if (int'(allot_r) > lpr_pkg::MAX_FRAMES) begin
      limit = lpr_pkg::CNT_W'(lpr_pkg::MAX_FRAMES);
    end else begin
      limit = lpr_pkg::CNT_W'(allot_r);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  assign req.valid = (cnt_r != 2'd0);
  assign req.page  = page_q_r[rd_ptr_r];
  assign req.limit = limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      allot_r  <= lpr_pkg::ALLOT_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (cfg_valid && cfg_ready) begin
        allot_r <= cfg_frames_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      page_q_r[wr_ptr_r] <= in_page_id[lpr_pkg::PAGE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/lpr_back.sv
`default_nettype none
module lpr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lpr_pkg::lpr_req_t req,
  output logic                   req_pop,
  output logic                   res_push,
  output lpr_pkg::lpr_res_t      res,
  input  wire logic              res_full
);

  localparam int N = lpr_pkg::MAX_FRAMES;

  typedef enum logic {S_LOOK, S_COMMIT} state_t;

  state_t                          state_r;
  logic [lpr_pkg::PAGE_BITS-1:0]   frame_page_r  [N];
  logic [N-1:0]                    frame_valid_r;
  logic [lpr_pkg::RANK_W-1:0]      frame_rank_r  [N];
  logic [lpr_pkg::RANK_W-1:0]      rank_nxt      [N];
  logic [lpr_pkg::CNT_W-1:0]       frames_filled_r;
  logic [lpr_pkg::FAULT_W-1:0]     fault_cnt_r;
  logic [lpr_pkg::FAULT_W-1:0]     fault_nxt;

  logic                            dec_hit_r;
  logic                            dec_fill_r;
  logic                            dec_repl_r;
  logic [lpr_pkg::IDX_W-1:0]       dec_idx_r;
  logic [lpr_pkg::PAGE_BITS-1:0]   dec_page_r;

  logic [N-1:0]                    elig;
  logic [N-1:0]                    match;
  logic [N-1:0]                    vict;
  logic [lpr_pkg::IDX_W-1:0]       hit_idx;
  logic [lpr_pkg::IDX_W-1:0]       vict_idx;
  logic                            hit_any;
  logic                            fill_ok;
  logic                            take;
  logic                            commit;

  assign take    = (state_r == S_LOOK) && req.valid;
  assign commit  = (state_r == S_COMMIT) && !res_full;
  assign req_pop = take;

  // classify against the current frame table
  always_comb begin
    for (int i = 0; i < N; i++) begin
      elig[i]  = (i < int'(req.limit));
      match[i] = frame_valid_r[i] && elig[i] && (frame_page_r[i] == req.page);
    end
    hit_any = |match;
    hit_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = lpr_pkg::IDX_W'(i);
      end
    end
    // ranks of valid frames are distinct: the victim beats every other candidate
    for (int i = 0; i < N; i++) begin
      vict[i] = elig[i] && frame_valid_r[i];
      for (int j = 0; j < N; j++) begin
        if (j != i && elig[j] && frame_valid_r[j] && !(frame_rank_r[j] < frame_rank_r[i])) begin
          vict[i] = 1'b0;
        end
      end
    end
    vict_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (vict[i]) begin
        vict_idx = vict_idx | lpr_pkg::IDX_W'(i);
      end
    end
    fill_ok = (frames_filled_r < req.limit);
  end

  // recency update: a fill ages every valid frame, otherwise only the younger ones
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = frame_rank_r[i];
      if (i == int'(dec_idx_r)) begin
        rank_nxt[i] = '0;
      end else if (frame_valid_r[i] &&
                   (dec_fill_r || (frame_rank_r[i] < frame_rank_r[dec_idx_r]))) begin
        rank_nxt[i] = frame_rank_r[i] + 1'b1;
      end
    end
  end

  assign fault_nxt = (dec_repl_r && (fault_cnt_r != lpr_pkg::FAULT_MAX)) ?
                     fault_cnt_r + 1'b1 : fault_cnt_r;

  assign res_push         = commit;
  assign res.hit          = dec_hit_r;
  assign res.filled_free  = dec_fill_r;
  assign res.replaced     = dec_repl_r;
  assign res.frame_index  = lpr_pkg::FRAME_OUT_W'(dec_idx_r);
  assign res.evicted_page = dec_repl_r ? lpr_pkg::PAGE_W'(frame_page_r[dec_idx_r]) : '0;
  assign res.fault_total  = fault_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_LOOK;
      frame_valid_r   <= '0;
      frames_filled_r <= '0;
      fault_cnt_r     <= '0;
      dec_hit_r       <= 1'b0;
      dec_fill_r      <= 1'b0;
      dec_repl_r      <= 1'b0;
      dec_idx_r       <= '0;
      for (int i = 0; i < N; i++) begin
        frame_rank_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_LOOK: begin
          if (take) begin
            dec_hit_r  <= hit_any;
            dec_fill_r <= !hit_any && fill_ok;
            dec_repl_r <= !hit_any && !fill_ok;
            if (hit_any) begin
              dec_idx_r <= hit_idx;
            end else if (fill_ok) begin
              dec_idx_r <= lpr_pkg::IDX_W'(frames_filled_r);
            end else begin
              dec_idx_r <= vict_idx;
            end
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            frame_rank_r <= rank_nxt;
            fault_cnt_r  <= fault_nxt;
            if (!dec_hit_r) begin
              frame_valid_r[dec_idx_r] <= 1'b1;
            end
            if (dec_fill_r) begin
              frames_filled_r <= frames_filled_r + 1'b1;
            end
            state_r <= S_LOOK;
          end
        end
        default: state_r <= S_LOOK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dec_page_r <= req.page;
    end
    if (commit && !dec_hit_r) begin
      frame_page_r[dec_idx_r] <= dec_page_r;
    end
  end

`ifndef SYNTH
  logic [N-1:0] valid_exp;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_exp[i] = (i < int'(frames_filled_r));
    end
  end

  a_res_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> $onehot({res.hit, res.filled_free, res.replaced}))
    else $error("outcome flags not one-hot");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    frame_valid_r == valid_exp)
    else $error("valid frames are not a prefix matching the fill count");

  a_victim_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) && (dec_repl_r || dec_hit_r) |-> frame_valid_r[dec_idx_r])
    else $error("hit or victim frame not valid");

  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> fault_cnt_r >= $past(fault_cnt_r))
    else $error("fault count went down");
`endif

endmodule
`default_nettype wire

// File: rtl/lpr_resq.sv
`default_nettype none
module lpr_resq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lpr_pkg::lpr_res_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output lpr_pkg::lpr_res_t      head
);

  localparam int QD = 2;

  lpr_pkg::lpr_res_t ent_r [QD];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == 2'(QD));
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lru_page_replacement_unit.sv
// channel  | direction | handshake         | payload
// in       | input     | in_push / in_full | in_page_id
// out      | output    | out_pop / out_empty | out_hit, out_filled_free, out_replaced,
//          |           |                   | out_frame_index, out_evicted_page, out_fault_total
// cfg      | input     | cfg_valid / cfg_ready | cfg_frames_in_use
//
// The back end takes each item through S_LOOK, which compares the page against all frames
// and picks the victim, then S_COMMIT, which updates pages, valid bits and recency ranks;
// it takes no new item until S_COMMIT is done. With the back end idle, an item passes
// through the input queue and the decision registers into the result queue, whose head drives the out ports.
// rst_n is synchronous; it clears valid bits, ranks, counters and both queues.
// A full result queue holds the back end in its update cycle; the input queue keeps
// taking items until it holds two.
`default_nettype none
module lru_page_replacement_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [lpr_pkg::PAGE_W-1:0]      in_page_id,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic                                 out_hit,
  output logic                                 out_filled_free,
  output logic                                 out_replaced,
  output logic [lpr_pkg::FRAME_OUT_W-1:0]      out_frame_index,
  output logic [lpr_pkg::PAGE_W-1:0]           out_evicted_page,
  output logic [lpr_pkg::FAULT_W-1:0]          out_fault_total,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lpr_pkg::ALLOT_W-1:0]     cfg_frames_in_use
);

  lpr_pkg::lpr_req_t req;
  lpr_pkg::lpr_res_t res;
  lpr_pkg::lpr_res_t head;
  logic              req_pop;
  logic              res_push;
  logic              res_full;

  lpr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_page_id        (in_page_id),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .req               (req),
    .req_pop           (req_pop)
  );

  lpr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .req_pop  (req_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  lpr_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (head)
  );

  assign out_hit          = head.hit;
  assign out_filled_free  = head.filled_free;
  assign out_replaced     = head.replaced;
  assign out_frame_index  = head.frame_index;
  assign out_evicted_page = head.evicted_page;
  assign out_fault_total  = head.fault_total;

endmodule
`default_nettype wire
